### rtl/sacc_pkg.sv
package sacc_pkg;

    localparam int MAX_PATTERN_BITS = 64;
    localparam int SAMPLE_WIDTH     = 16;
    localparam int OUT_SAMPLE_WIDTH = 16;

    localparam int HIST_BITS       = 64;
    localparam int GROUP_BITS      = 8;
    localparam int GROUPS          = HIST_BITS / GROUP_BITS;
    localparam int GROUP_CNT_WIDTH = $clog2(GROUP_BITS + 1);
    localparam int COUNT_WIDTH     = $clog2(HIST_BITS + 1);

    localparam int CFG_WIDTH       = 64;
    localparam int LEN_WIDTH       = 7;
    localparam int TAG_WIDTH       = 64;
    localparam int REG_INDEX_WIDTH = 2;

    // rate 1/2, K=7 encoder; second output is inverted
    localparam int           ENC_SPAN        = 7;
    localparam logic [6:0]   POLY_FIRST      = 7'h4f;
    localparam logic [6:0]   POLY_SECOND     = 7'h6d;
    localparam int           CONV_DROP_BITS  = 16;
    localparam int           CONV_LEN_MIN    = 17;
    localparam int           CONV_LEN_MAX    = 48;
    localparam int           PLAIN_LEN_MIN   = 1;
    localparam int           PLAIN_LEN_MAX   = 64;
    localparam logic [TAG_WIDTH-1:0] CONV_TAG_OFFSET = TAG_WIDTH'(80);

    typedef enum logic [REG_INDEX_WIDTH-1:0] {
        REG_CODE_BITS,
        REG_CODE_LENGTH,
        REG_THRESHOLD,
        REG_CONV_ENABLE
    } reg_index_t;

    typedef struct packed {
        logic [HIST_BITS-1:0] pattern;
        logic [HIST_BITS-1:0] mask;
        logic [LEN_WIDTH-1:0] threshold;
        logic                 conv_enable;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0]                     sample;
        logic [GROUPS-1:0][GROUP_CNT_WIDTH-1:0]      wrong;
        logic [GROUPS-1:0][GROUP_CNT_WIDTH-1:0]      wrong_inv;
    } corr_t;

endpackage

### rtl/sacc_config.sv
module sacc_config (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 write_enable,
    input  logic [sacc_pkg::REG_INDEX_WIDTH-1:0] write_index,
    input  logic [sacc_pkg::CFG_WIDTH-1:0]       write_data,
    output sacc_pkg::cfg_t                       cfg,
    output logic                                 hist_clear
);
    import sacc_pkg::*;

    localparam logic [HIST_BITS-1:0] RESET_MASK =
        (MAX_PATTERN_BITS >= HIST_BITS) ? {HIST_BITS{1'b1}}
                                        : ((HIST_BITS'(1) << MAX_PATTERN_BITS) - HIST_BITS'(1));

    logic [CFG_WIDTH-1:0] code_bits_reg;
    logic [LEN_WIDTH-1:0] code_length_reg;
    logic [LEN_WIDTH-1:0] threshold_reg;
    logic                 conv_enable_reg;
    logic [HIST_BITS-1:0] pattern_reg;
    logic [HIST_BITS-1:0] mask_reg;

    logic [HIST_BITS-1:0] pattern_next;
    logic [HIST_BITS-1:0] mask_next;
    logic [HIST_BITS-1:0] code_masked;
    logic [HIST_BITS-1:0] conv_pattern;
    logic [LEN_WIDTH-1:0] plain_len;
    logic [LEN_WIDTH-1:0] conv_len;
    logic [LEN_WIDTH-1:0] pattern_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_bits_reg   <= '0;
            code_length_reg <= LEN_WIDTH'(PLAIN_LEN_MAX);
            threshold_reg   <= '0;
            conv_enable_reg <= 1'b0;
        end
        else if (write_enable)
        begin
            unique case (reg_index_t'(write_index))
                REG_CODE_BITS:   code_bits_reg   <= write_data;
                REG_CODE_LENGTH: code_length_reg <= write_data[LEN_WIDTH-1:0];
                REG_THRESHOLD:   threshold_reg   <= write_data[LEN_WIDTH-1:0];
                REG_CONV_ENABLE: conv_enable_reg <= write_data[0];
            endcase
        end
    end

    assign hist_clear = write_enable && (reg_index_t'(write_index) != REG_THRESHOLD);

    always_comb
    begin
        if (code_length_reg < LEN_WIDTH'(PLAIN_LEN_MIN))
            plain_len = LEN_WIDTH'(PLAIN_LEN_MIN);
        else if (code_length_reg > LEN_WIDTH'(PLAIN_LEN_MAX))
            plain_len = LEN_WIDTH'(PLAIN_LEN_MAX);
        else
            plain_len = code_length_reg;

        if (code_length_reg < LEN_WIDTH'(CONV_LEN_MIN))
            conv_len = LEN_WIDTH'(CONV_LEN_MIN);
        else if (code_length_reg > LEN_WIDTH'(CONV_LEN_MAX))
            conv_len = LEN_WIDTH'(CONV_LEN_MAX);
        else
            conv_len = code_length_reg;

        for (int i = 0; i < HIST_BITS; i++)
            code_masked[i] = code_bits_reg[i] && (LEN_WIDTH'(i) < conv_len);

        if (conv_enable_reg)
            pattern_len = LEN_WIDTH'({conv_len, 1'b0} - (LEN_WIDTH + 1)'(2 * CONV_DROP_BITS));
        else
            pattern_len = plain_len;

        for (int p = 0; p < HIST_BITS; p++)
            mask_next[p] = (LEN_WIDTH'(p) < pattern_len) && (p < MAX_PATTERN_BITS);

        pattern_next = (conv_enable_reg ? conv_pattern : code_bits_reg) & mask_next;
    end

    // Kept coded bits map to fixed code positions: pattern bit p comes from the
    // encoder window starting at code bit R, independent of the code length.
    for (genvar p = 0; p < HIST_BITS; p++)
    begin : g_conv
        if (p % 2 == 1)
        begin : g_first
            localparam int R = (CONV_DROP_BITS - 1 + p) / 2;
            assign conv_pattern[p] = ^(code_masked[R +: ENC_SPAN] & POLY_FIRST);
        end
        else
        begin : g_second
            localparam int R = CONV_DROP_BITS / 2 + p / 2;
            assign conv_pattern[p] = ~^(code_masked[R +: ENC_SPAN] & POLY_SECOND);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            mask_reg    <= RESET_MASK;
        end
        else
        begin
            pattern_reg <= pattern_next;
            mask_reg    <= mask_next;
        end
    end

    assign cfg.pattern     = pattern_reg;
    assign cfg.mask        = mask_reg;
    assign cfg.threshold   = threshold_reg;
    assign cfg.conv_enable = conv_enable_reg;

`ifndef SYNTHESIS
    a_pattern_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (pattern_reg & ~mask_reg) == '0)
        else $error("pattern has bits outside the compare mask");

    a_mask_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        mask_reg[0])
        else $error("compare mask is empty");
`endif

endmodule

### rtl/sacc_compare.sv
module sacc_compare (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic                              hist_clear,
    input  logic [sacc_pkg::SAMPLE_WIDTH-1:0] sample,
    input  sacc_pkg::cfg_t                    cfg,
    output sacc_pkg::corr_t                   corr
);
    import sacc_pkg::*;

    logic [HIST_BITS-1:0] history_reg;
    logic [HIST_BITS-1:0] history_next;
    logic [HIST_BITS-1:0] diff;
    logic                 positive;
    corr_t                corr_reg;
    corr_t                corr_next;

    function automatic logic [GROUP_CNT_WIDTH-1:0] group_ones(input logic [GROUP_BITS-1:0] v);
        logic [GROUP_CNT_WIDTH-1:0] n;
        n = '0;
        for (int i = 0; i < GROUP_BITS; i++)
            n = n + GROUP_CNT_WIDTH'(v[i]);
        return n;
    endfunction

    always_comb
    begin
        positive     = (sample != '0) && !sample[SAMPLE_WIDTH-1];
        history_next = {history_reg[HIST_BITS-2:0], positive};
        diff         = history_next ^ cfg.pattern;
        corr_next.sample = sample;
        for (int g = 0; g < GROUPS; g++)
        begin
            corr_next.wrong[g]     = group_ones(diff[g*GROUP_BITS +: GROUP_BITS]
                                                & cfg.mask[g*GROUP_BITS +: GROUP_BITS]);
            corr_next.wrong_inv[g] = group_ones(~diff[g*GROUP_BITS +: GROUP_BITS]
                                                & cfg.mask[g*GROUP_BITS +: GROUP_BITS]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            history_reg <= '0;
        else if (hist_clear)
            history_reg <= '0;
        else if (load)
            history_reg <= history_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            corr_reg <= corr_next;
    end

    assign corr = corr_reg;

`ifndef SYNTHESIS
    a_hist_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        hist_clear |=> history_reg == '0)
        else $error("history not cleared after code write");
`endif

endmodule

### rtl/sacc_decide.sv
module sacc_decide (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  load,
    input  sacc_pkg::corr_t                       corr,
    input  sacc_pkg::cfg_t                        cfg,
    output logic [sacc_pkg::OUT_SAMPLE_WIDTH-1:0] sample_out,
    output logic                                  match,
    output logic                                  inverted,
    output logic [sacc_pkg::TAG_WIDTH-1:0]        tag_position
);
    import sacc_pkg::*;

    logic                        inverted_flag_reg;
    logic                        inverted_flag_next;
    logic [TAG_WIDTH-1:0]        count_reg;
    logic [OUT_SAMPLE_WIDTH-1:0] sample_out_reg;
    logic                        match_reg;
    logic [TAG_WIDTH-1:0]        tag_reg;
    logic [TAG_WIDTH-1:0]        tag_next;
    logic [COUNT_WIDTH-1:0]      wrong_sum;
    logic [COUNT_WIDTH-1:0]      wrong_inv_sum;
    logic                        hit_plain;
    logic                        hit_inv;
    logic                        hit;

    always_comb
    begin
        wrong_sum     = '0;
        wrong_inv_sum = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            wrong_sum     = wrong_sum + COUNT_WIDTH'(corr.wrong[g]);
            wrong_inv_sum = wrong_inv_sum + COUNT_WIDTH'(corr.wrong_inv[g]);
        end
        hit_plain = COUNT_WIDTH'(wrong_sum) <= COUNT_WIDTH'(cfg.threshold);
        hit_inv   = COUNT_WIDTH'(wrong_inv_sum) <= COUNT_WIDTH'(cfg.threshold);
        hit       = hit_plain || hit_inv;

        // both within threshold reports as inverted
        inverted_flag_next = hit ? hit_inv : inverted_flag_reg;
        if (hit)
            tag_next = count_reg + (cfg.conv_enable ? CONV_TAG_OFFSET : '0);
        else
            tag_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverted_flag_reg <= 1'b0;
            count_reg         <= '0;
        end
        else if (load)
        begin
            inverted_flag_reg <= inverted_flag_next;
            count_reg         <= count_reg + TAG_WIDTH'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_out_reg <= OUT_SAMPLE_WIDTH'(corr.sample);
            match_reg      <= hit;
            tag_reg        <= tag_next;
        end
    end

    assign sample_out   = sample_out_reg;
    assign match        = match_reg;
    assign inverted     = inverted_flag_reg;
    assign tag_position = tag_reg;

`ifndef SYNTHESIS
    a_miss_holds_flag: assert property (@(posedge clk) disable iff (!rst_n)
        load && !hit |=> $stable(inverted_flag_reg) && tag_reg == '0)
        else $error("miss changed inverted flag or produced a tag");
`endif

endmodule

### rtl/soft_access_code_correlator.sv
// Pipeline: a sample passes the input register, the compare stage and the decide stage in that order.
// Throughput: one sample per cycle while result_stall does not hold the output; the history shift,
// the sample counter and the inverted flag each close their loop through a single register.
// Reset (rst_n, async, active low): pipeline empty, history, inverted flag and
// sample count cleared, registers back to code 0, length 64, threshold 0, plain mode.
module soft_access_code_correlator (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        sample_valid,
    output logic                                        sample_stall,
    input  logic signed [sacc_pkg::SAMPLE_WIDTH-1:0]     sample,
    output logic                                        result_valid,
    input  logic                                        result_stall,
    output logic signed [sacc_pkg::OUT_SAMPLE_WIDTH-1:0] sample_out,
    output logic                                        match,
    output logic                                        inverted,
    output logic [sacc_pkg::TAG_WIDTH-1:0]              tag_position,
    input  logic                                        write_enable,
    input  logic [sacc_pkg::REG_INDEX_WIDTH-1:0]        write_index,
    input  logic [sacc_pkg::CFG_WIDTH-1:0]              write_data
);
    import sacc_pkg::*;

    logic                        in_valid_reg;
    logic                        mid_valid_reg;
    logic                        out_valid_reg;
    logic [SAMPLE_WIDTH-1:0]     sample_reg;
    logic                        load_in;
    logic                        load_mid;
    logic                        load_out;
    logic                        hist_clear;
    cfg_t                        cfg;
    corr_t                       corr;
    logic [OUT_SAMPLE_WIDTH-1:0] sample_out_w;

    // each stage advances when the next one is empty or moving
    assign load_out     = mid_valid_reg && (!out_valid_reg || !result_stall);
    assign load_mid     = in_valid_reg && (!mid_valid_reg || load_out);
    assign sample_stall = in_valid_reg && !load_mid;
    assign load_in      = sample_valid && !sample_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= load_in || (in_valid_reg && !load_mid);
            mid_valid_reg <= load_mid || (mid_valid_reg && !load_out);
            out_valid_reg <= load_out || (out_valid_reg && result_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
            sample_reg <= unsigned'(sample);
    end

    sacc_config u_config (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .cfg          (cfg),
        .hist_clear   (hist_clear)
    );

    sacc_compare u_compare (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load_mid),
        .hist_clear (hist_clear),
        .sample     (sample_reg),
        .cfg        (cfg),
        .corr       (corr)
    );

    sacc_decide u_decide (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load_out),
        .corr         (corr),
        .cfg          (cfg),
        .sample_out   (sample_out_w),
        .match        (match),
        .inverted     (inverted),
        .tag_position (tag_position)
    );

    assign result_valid = out_valid_reg;
    assign sample_out   = signed'(sample_out_w);

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> mid_valid_reg && out_valid_reg && result_stall)
        else $error("input stalled while the pipeline has room");

    a_no_tag_without_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !match |-> tag_position == '0)
        else $error("tag position reported without a match");
`endif

endmodule

### dv/soft_access_code_correlator_tb.sv
`timescale 1ns / 1ps

module soft_access_code_correlator_tb;

    import sacc_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SEGMENTS      = 4;
    localparam int SEG_ITEMS     = 50;

    typedef struct packed {
        logic signed [OUT_SAMPLE_WIDTH-1:0] sample_out;
        logic                               match;
        logic                               inverted;
        logic [TAG_WIDTH-1:0]               tag_position;
    } det_result_t;

    typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                      kind;
        reg_index_t                     idx;
        logic [CFG_WIDTH-1:0]           data;
        logic signed [SAMPLE_WIDTH-1:0] smp;
        bit                             typed;
        det_result_t                    res;
    } dir_row_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                sample_valid = 1'b0;
    logic                                sample_stall;
    logic signed [SAMPLE_WIDTH-1:0]      sample = '0;
    logic                                result_valid;
    logic                                result_stall = 1'b0;
    logic signed [OUT_SAMPLE_WIDTH-1:0]  sample_out;
    logic                                match;
    logic                                inverted;
    logic [TAG_WIDTH-1:0]                tag_position;
    logic                                write_enable = 1'b0;
    logic [REG_INDEX_WIDTH-1:0]          write_index = '0;
    logic [CFG_WIDTH-1:0]                write_data = '0;

    soft_access_code_correlator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample_out   (sample_out),
        .match        (match),
        .inverted     (inverted),
        .tag_position (tag_position),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data)
    );

    // correlator shadow state
    logic [63:0]     code_word;
    logic [6:0]      code_len;
    int              thr;
    bit              conv_on;
    logic [63:0]     history;
    logic [63:0]     pat_word;
    logic [63:0]     pat_mask;
    int              pat_len;
    bit              inv_flag;
    logic [63:0]     sample_idx;

    det_result_t     predicted_q[$];
    int              errors = 0;
    int              items_sent = 0;
    int              results_checked = 0;
    int              match_count = 0;
    int              inv_count = 0;
    int              cfg_writes = 0;
    int              src_idle_pct = 13;
    int              sink_idle_pct = 78;
    bit              hold_request = 1'b0;
    bit              streaming = 1'b0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    // rebuild the compared pattern; any code change also clears the history
    function automatic void build_pattern();
        int          n;
        int          plen;
        logic [6:0]  enc;
        logic [63:0] pat;
        bit          a;
        bit          b;
        n = code_len;
        pat = '0;
        if (conv_on)
        begin
            if (n < CONV_LEN_MIN) n = CONV_LEN_MIN;
            if (n > CONV_LEN_MAX) n = CONV_LEN_MAX;
            enc = '0;
            for (int i = 0; i < n; i++)
            begin
                enc = {enc[5:0], code_word[n-1-i]};
                a = ^(enc & POLY_FIRST);
                b = ~^(enc & POLY_SECOND);
                if (2*i >= CONV_DROP_BITS && 2*i < 2*n - CONV_DROP_BITS)
                    pat = {pat[62:0], a};
                if (2*i + 1 >= CONV_DROP_BITS && 2*i + 1 < 2*n - CONV_DROP_BITS)
                    pat = {pat[62:0], b};
            end
            plen = 2*n - 2*CONV_DROP_BITS;
        end
        else
        begin
            if (n < PLAIN_LEN_MIN) n = PLAIN_LEN_MIN;
            if (n > PLAIN_LEN_MAX) n = PLAIN_LEN_MAX;
            pat = code_word;
            plen = n;
        end
        pat_len = plen;
        pat_mask = (plen >= 64) ? '1 : (64'd1 << plen) - 64'd1;
        pat_word = pat & pat_mask;
        history = '0;
    endfunction

    function automatic det_result_t correlate_sample(logic signed [SAMPLE_WIDTH-1:0] s);
        det_result_t r;
        logic [63:0] diff;
        int          nw;
        int          ni;
        bit          hit;
        history = {history[62:0], (s > 0)};
        diff = history ^ pat_word;
        nw = $countones(diff & pat_mask);
        ni = $countones(~diff & pat_mask);
        hit = (nw <= thr) || (ni <= thr);
        r.sample_out = s;
        r.match = hit;
        r.tag_position = '0;
        if (hit)
        begin
            inv_flag = (ni <= thr);
            r.tag_position = sample_idx + (conv_on ? CONV_TAG_OFFSET : '0);
        end
        r.inverted = inv_flag;
        sample_idx++;
        return r;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] soft_bit(bit b);
        case ($urandom_range(0, 15))
            0: return b ? 16'sh7FFF : 16'sh8000;
            1: return b ? 16'sd1 : 16'sd0;
            default: return b ? 16'($urandom_range(1, 32767))
                              : 16'(-int'($urandom_range(0, 32768)));
        endcase
    endfunction

    function automatic dir_row_t wr_row(reg_index_t idx, logic [63:0] d);
        return '{ROW_WRITE, idx, d, '0, 1'b0, '0};
    endfunction

    function automatic dir_row_t smp_row(logic signed [15:0] s);
        return '{ROW_SAMPLE, REG_CODE_BITS, '0, s, 1'b0, '0};
    endfunction

    function automatic dir_row_t smp_known(logic signed [15:0] s, bit m, bit inv,
                                           logic [63:0] tag);
        return '{ROW_SAMPLE, REG_CODE_BITS, '0, s, 1'b1, '{s, m, inv, tag}};
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s,
                               input bit typed = 1'b0,
                               input det_result_t typed_res = '0);
        det_result_t r;
        write_enable <= 1'b0;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        streaming = 1'b1;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
        r = correlate_sample(s);
        predicted_q.insert(predicted_q.size(), typed ? typed_res : r);
        items_sent++;
    endtask

    // drain the pipeline before touching registers
    task automatic settle();
        if (streaming)
        begin
            streaming = 1'b0;
            sample_valid <= 1'b0;
            @(posedge clk);
            while (predicted_q.size() != 0) @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [63:0] d);
        write_enable <= 1'b1;
        write_index <= idx;
        write_data <= d;
        @(posedge clk);
        case (idx)
            REG_CODE_BITS:   begin code_word = d; build_pattern(); end
            REG_CODE_LENGTH: begin code_len = d[6:0]; build_pattern(); end
            REG_THRESHOLD:   thr = d[6:0];
            REG_CONV_ENABLE: begin conv_on = d[0]; build_pattern(); end
        endcase
        cfg_writes++;
    endtask

    // pattern (or its inverse) with a few flipped bits, oldest bit first
    task automatic send_frame();
        logic [63:0] bits;
        int          flips;
        bits = ($urandom_range(0, 3) == 0) ? (pat_word ^ pat_mask) : pat_word;
        flips = $urandom_range(0, 3);
        repeat (flips) bits[$urandom_range(0, pat_len - 1)] ^= 1'b1;
        for (int i = pat_len - 1; i >= 0; i--)
            send_sample(soft_bit(bits[i]));
    endtask

    // output side: random stall, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_stall <= ($urandom_range(0, 99) < sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        det_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (predicted_q.size() == 0)
            begin
                $display("%0t: unexpected transaction sample_out=%0d match=%0b tag=%0d",
                         $time, sample_out, match, tag_position);
                errors++;
            end
            else
            begin
                want = predicted_q.pop_front();
                results_checked++;
                if (sample_out !== want.sample_out)
                begin
                    $display("%0t: sample_out expected %0d actual %0d",
                             $time, want.sample_out, sample_out);
                    errors++;
                end
                if (match !== want.match)
                begin
                    $display("%0t: match expected %0b actual %0b", $time, want.match, match);
                    errors++;
                end
                if (inverted !== want.inverted)
                begin
                    $display("%0t: inverted expected %0b actual %0b",
                             $time, want.inverted, inverted);
                    errors++;
                end
                if (tag_position !== want.tag_position)
                begin
                    $display("%0t: tag_position expected %0d actual %0d",
                             $time, want.tag_position, tag_position);
                    errors++;
                end
                if (match === 1'b1) match_count++;
                if (match === 1'b1 && inverted === 1'b1) inv_count++;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        dir_row_t    dir_tab[$];
        reg_index_t  idx;
        logic [63:0] val;
        logic [63:0] junk;
        logic [6:0]  v7;
        int          start;
        int          stop_at;
        bit          retune;

        code_word = '0;
        code_len = 7'd64;
        thr = 0;
        conv_on = 1'b0;
        inv_flag = 1'b0;
        sample_idx = '0;
        build_pattern();

        // out of reset: all-zero code of 64 bits, zero threshold
        dir_tab.insert(dir_tab.size(), smp_known(16'sd0,    1'b1, 1'b0, 64'd0));
        dir_tab.insert(dir_tab.size(), smp_known(16'sh8000, 1'b1, 1'b0, 64'd1));
        dir_tab.insert(dir_tab.size(), smp_known(16'sh7FFF, 1'b0, 1'b0, 64'd0));
        dir_tab.insert(dir_tab.size(), smp_known(16'shFFFF, 1'b0, 1'b0, 64'd0));
        dir_tab.insert(dir_tab.size(), smp_row(16'sd1));
        dir_tab.insert(dir_tab.size(), wr_row(REG_CODE_LENGTH, 64'd4));
        dir_tab.insert(dir_tab.size(), wr_row(REG_CODE_BITS, 64'hA));
        dir_tab.insert(dir_tab.size(), smp_row(16'sd100));
        dir_tab.insert(dir_tab.size(), smp_row(-16'sd100));
        dir_tab.insert(dir_tab.size(), smp_row(16'sd200));
        dir_tab.insert(dir_tab.size(), smp_row(-16'sd7));
        dir_tab.insert(dir_tab.size(), smp_row(-16'sd3));
        dir_tab.insert(dir_tab.size(), smp_row(16'sd9));
        dir_tab.insert(dir_tab.size(), smp_row(16'sh8000));
        dir_tab.insert(dir_tab.size(), smp_row(16'sh7FFF));
        // threshold covers the whole pattern: both polarities match
        dir_tab.insert(dir_tab.size(), wr_row(REG_THRESHOLD, 64'd64));
        dir_tab.insert(dir_tab.size(), smp_row(16'sd5));
        dir_tab.insert(dir_tab.size(), smp_row(-16'sd5));
        dir_tab.insert(dir_tab.size(), wr_row(REG_THRESHOLD, 64'd1));
        dir_tab.insert(dir_tab.size(), wr_row(REG_CODE_LENGTH, 64'd0));
        dir_tab.insert(dir_tab.size(), smp_row(16'sd1));
        dir_tab.insert(dir_tab.size(), smp_row(16'sd0));
        dir_tab.insert(dir_tab.size(), wr_row(REG_CODE_LENGTH, 64'd127));
        dir_tab.insert(dir_tab.size(), smp_row(16'sh7FFF));
        dir_tab.insert(dir_tab.size(), wr_row(REG_CONV_ENABLE, 64'd1));
        dir_tab.insert(dir_tab.size(), wr_row(REG_CODE_LENGTH, 64'd5));
        dir_tab.insert(dir_tab.size(), wr_row(REG_THRESHOLD, 64'd0));
        dir_tab.insert(dir_tab.size(), wr_row(REG_CODE_BITS, 64'h1ACF_FC1D_0F0F_5A5A));
        dir_tab.insert(dir_tab.size(), smp_row(16'sd1));
        dir_tab.insert(dir_tab.size(), smp_row(-16'sd1));
        dir_tab.insert(dir_tab.size(), smp_row(16'sd1));
        dir_tab.insert(dir_tab.size(), wr_row(REG_CODE_LENGTH, 64'd100));
        dir_tab.insert(dir_tab.size(), smp_row(16'sd1234));
        dir_tab.insert(dir_tab.size(), smp_row(-16'sd1234));
        dir_tab.insert(dir_tab.size(), wr_row(REG_CONV_ENABLE, 64'd0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[r])
        begin
            if (dir_tab[r].kind == ROW_WRITE)
            begin
                settle();
                write_reg(dir_tab[r].idx, dir_tab[r].data);
            end
            else
                send_sample(dir_tab[r].smp, dir_tab[r].typed, dir_tab[r].res);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct  = (ph == 0) ? 13 : (ph == 1) ? 78 : 0;
            sink_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 13 : 0;
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                settle();
                start = $urandom_range(0, 3);
                for (int k = 0; k < 4; k++)
                begin
                    idx = reg_index_t'((start + k) % 4);
                    junk = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
                    case (idx)
                        REG_CODE_BITS: val = {$urandom, $urandom};
                        REG_CODE_LENGTH:
                        begin
                            case ($urandom_range(0, 9))
                                0: v7 = 7'd0;
                                1: v7 = 7'd1;
                                2: v7 = 7'd64;
                                3: v7 = 7'd127;
                                4: v7 = 7'd17;
                                5: v7 = 7'd48;
                                6: v7 = 7'd16;
                                default: v7 = 7'($urandom_range(1, 64));
                            endcase
                            val = {junk[63:7], v7};
                        end
                        REG_THRESHOLD:
                        begin
                            case ($urandom_range(0, 11))
                                0: v7 = 7'd64;
                                1: v7 = 7'd127;
                                2: v7 = 7'd0;
                                default: v7 = 7'($urandom_range(0, 6));
                            endcase
                            val = {junk[63:7], v7};
                        end
                        REG_CONV_ENABLE: val = {junk[63:1], 1'($urandom_range(0, 1))};
                    endcase
                    write_reg(idx, val);
                end
                if (ph == 2 && seg == 0)
                    hold_request = 1'b1;
                stop_at = items_sent + SEG_ITEMS;
                retune = $urandom_range(0, 1);
                while (items_sent < stop_at)
                begin
                    // threshold change mid-stream keeps the history
                    if (retune && items_sent >= stop_at - SEG_ITEMS / 2)
                    begin
                        retune = 1'b0;
                        settle();
                        write_reg(REG_THRESHOLD, 64'($urandom_range(0, 8)));
                    end
                    if ($urandom_range(0, 9) < 7)
                        send_frame();
                    else
                        repeat ($urandom_range(1, 24)) send_sample(16'($urandom));
                end
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (predicted_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, predicted_q.size());
            errors++;
        end
        $display("Sent %0d samples across %0d register writes, three stall mixes",
                 items_sent, cfg_writes);
        $display("and a %0d-cycle output hold-off; checked %0d results: %0d matches, %0d inverted.",
                 HOLD_CYCLES, results_checked, match_count, inv_count);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
